@@ hw/rtl/asd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants of the AAC superframe demultiplexer
// Word kinds, error codes, register indexes, controller/datapath links and
// the frame-count and header-size helpers.
// ----------------------------------------------------------------------------
package asd_pkg;

	localparam int MAX_FRAMES_DEF  = 10;
	localparam int LENGTH_BITS_DEF = 14;

	localparam int BYTE_W   = 8;
	localparam int BORDER_W = 12;
	localparam int ACC_W    = 20;
	localparam int ACC_BITS_W = 5;
	localparam int KIND_W   = 2;
	localparam int FIDX_W   = 4;
	localparam int OFS_W    = 14;
	localparam int ERR_W    = 2;
	localparam int MODE_W   = 3;
	localparam int RATE_W   = 2;
	localparam int PART_W   = 13;
	localparam int PAY_W    = 14;
	localparam int SUM_W    = 15;
	localparam int HPC_W    = 14;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W    = 13;

	typedef enum logic [KIND_W-1:0] {
		KIND_HEADER  = 2'd0,
		KIND_AUDIO   = 2'd1,
		KIND_CRC     = 2'd2,
		KIND_DISCARD = 2'd3
	} kind_t;

	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NO_FRAMES = 2'd1;
	localparam logic [ERR_W-1:0] ERR_BORDER    = 2'd2;
	localparam logic [ERR_W-1:0] ERR_SHORT     = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RATE  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEN_A = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_LEN_B = 2'd3;

	localparam logic [MODE_W-1:0] MODE_D    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_E    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_NONE = 3'd5;
	localparam logic [RATE_W-1:0] RATE_12K   = 2'd0;
	localparam logic [RATE_W-1:0] RATE_24K   = 2'd1;
	localparam logic [RATE_W-1:0] RATE_48K   = 2'd2;
	localparam logic [RATE_W-1:0] RATE_OTHER = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [RATE_W-1:0] rate;
		logic [PART_W-1:0] len_a;
		logic [PART_W-1:0] len_b;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic fin;
		logic div;
		logic check;
		logic search;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic step_fin;
		logic step_search;
		logic fin_err;
		logic fin_div;
		logic div_last;
		logic check_stop;
		logic search_stop;
		logic out_free;
	} sts_t;

	function automatic logic [3:0] frames_for_config(input logic [MODE_W-1:0] mode,
		input logic [RATE_W-1:0] rate);
		logic [3:0] n;
		n = 4'd0;
		if (mode <= MODE_D) begin
			if (rate == RATE_12K) n = 4'd5;
			else if (rate == RATE_24K) n = 4'd10;
		end else if (mode == MODE_E) begin
			if (rate == RATE_24K) n = 4'd5;
			else if (rate == RATE_48K) n = 4'd10;
		end
		return n;
	endfunction

	// header bytes: 12-bit borders for all but the last frame, plus 4 reserved
	// bits with ten frames
	function automatic logic [3:0] header_len(input logic [3:0] n);
		logic [7:0] bits;
		bits = 8'd12 * (8'(n) - 8'd1) + ((n == 4'd10) ? 8'd4 : 8'd0);
		return 4'(bits >> 3);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/asd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_in_if / asd_out_if: byte and result channels
// Valid/ready channels carrying one superframe byte or one tagged result.
// ----------------------------------------------------------------------------
interface asd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       superframe_start;
	modport source(output valid, in_byte, superframe_start, input ready);
	modport sink(input valid, in_byte, superframe_start, output ready);
endinterface

interface asd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_kind;
	logic [7:0]  out_byte;
	logic [3:0]  frame_index;
	logic [13:0] byte_offset;
	logic        frame_done;
	logic        superframe_done;
	logic [1:0]  error_code;
	modport source(output valid, item_kind, out_byte, frame_index, byte_offset,
		frame_done, superframe_done, error_code, input ready);
	modport sink(input valid, item_kind, out_byte, frame_index, byte_offset,
		frame_done, superframe_done, error_code, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/aac_superframe_demux.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted byte passes the step state and, as needed, the header finish,
// divider, length check and search states before the out state loads the output
// register; the divider runs only when length_part_a is nonzero, and a frame end
// searches the following frames for a nonempty lower part. One byte is in flight
// at a time: intake stays closed until the result enters the output register.
// Reset: control and configuration cleared at once; frame lengths undefined.
// ----------------------------------------------------------------------------
// aac_superframe_demux: AAC audio superframe demultiplexer
// Parses frame borders from the superframe header and tags each byte as
// header, audio, CRC or discarded, with frame index, offset and errors.
// ----------------------------------------------------------------------------
module aac_superframe_demux #(
	parameter int MAX_FRAMES  = asd_pkg::MAX_FRAMES_DEF,
	parameter int LENGTH_BITS = asd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [asd_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [asd_pkg::CFG_W-1:0]         cfg_wdata,
	asd_in_if.sink                                 byte_in,
	asd_out_if.source                              item_out
);
	import asd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_NONE;
			cfg_q.rate  <= RATE_OTHER;
			cfg_q.len_a <= '0;
			cfg_q.len_b <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  cfg_q.mode  <= MODE_W'(cfg_wdata);
				REG_RATE:  cfg_q.rate  <= RATE_W'(cfg_wdata);
				REG_LEN_A: cfg_q.len_a <= PART_W'(cfg_wdata);
				REG_LEN_B: cfg_q.len_b <= PART_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	asd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_in.valid),
		.in_ready (byte_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	asd_dp #(
		.MAX_FRAMES  (MAX_FRAMES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_byte          (byte_in.in_byte),
		.superframe_start (byte_in.superframe_start),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (item_out.ready),
		.out_valid        (item_out.valid),
		.item_kind        (item_out.item_kind),
		.out_byte         (item_out.out_byte),
		.frame_index      (item_out.frame_index),
		.byte_offset      (item_out.byte_offset),
		.frame_done       (item_out.frame_done),
		.superframe_done  (item_out.superframe_done),
		.error_code       (item_out.error_code)
	);

	// one word in flight: intake closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in.valid && byte_in.ready |=> !byte_in.ready)
		else $error("byte accepted while another is in flight");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && (item_out.item_kind == KIND_AUDIO ||
		item_out.item_kind == KIND_CRC) |-> item_out.error_code == ERR_NONE)
		else $error("payload word tagged with an error");

	a_done_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.superframe_done |->
		item_out.item_kind == KIND_AUDIO || item_out.item_kind == KIND_CRC)
		else $error("superframe end flagged on a non-payload word");

endmodule
`default_nettype wire

@@ hw/rtl/asd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_ctrl: demultiplexer sequencer
// Walks each accepted word through step and, as needed, header finish, division,
// length check, lower-part search, then result hand-off.
// ----------------------------------------------------------------------------
module asd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  asd_pkg::sts_t      sts,
	output asd_pkg::cmd_t      cmd
);
	import asd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_STEP, S_FIN, S_DIV, S_CHECK, S_SEARCH, S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_STEP;
				end
				S_STEP: begin
					if (sts.step_fin) state_q <= S_FIN;
					else if (sts.step_search) state_q <= S_SEARCH;
					else state_q <= S_OUT;
				end
				S_FIN: begin
					if (sts.fin_err) state_q <= S_OUT;
					else if (sts.fin_div) state_q <= S_DIV;
					else state_q <= S_CHECK;
				end
				S_DIV: begin
					if (sts.div_last) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.check_stop) state_q <= S_OUT;
				end
				S_SEARCH: begin
					if (sts.search_stop) state_q <= S_OUT;
				end
				S_OUT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && in_valid;
	assign cmd.step   = (state_q == S_STEP);
	assign cmd.fin    = (state_q == S_FIN);
	assign cmd.div    = (state_q == S_DIV);
	assign cmd.check  = (state_q == S_CHECK);
	assign cmd.search = (state_q == S_SEARCH);
	assign cmd.emit   = (state_q == S_OUT) && sts.out_free;

endmodule
`default_nettype wire

@@ hw/rtl/asd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asd_dp: demultiplexer datapath
// Parse state, border accumulator, frame length store, serial divider and
// the result register.
// ----------------------------------------------------------------------------
module asd_dp #(
	parameter int MAX_FRAMES  = asd_pkg::MAX_FRAMES_DEF,
	parameter int LENGTH_BITS = asd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  asd_pkg::cfg_t               cfg,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   superframe_start,
	input  asd_pkg::cmd_t               cmd,
	output asd_pkg::sts_t               sts,
	input  wire logic                   out_ready,
	output logic                        out_valid,
	output logic [1:0]                  item_kind,
	output logic [7:0]                  out_byte,
	output logic [3:0]                  frame_index,
	output logic [13:0]                 byte_offset,
	output logic                        frame_done,
	output logic                        superframe_done,
	output logic [1:0]                  error_code
);
	import asd_pkg::*;

	localparam int LB     = LENGTH_BITS;
	localparam int FI_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W  = ((LB > HPC_W) ? LB : HPC_W) + 1;
	localparam int LEN_LIMIT = (1 << LB) - 1;
	localparam int DIV_STEPS = PART_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		PH_IDLE, PH_HDR, PH_HPP, PH_LPP, PH_DONE, PH_ERR
	} phase_t;

	phase_t                  phase_q;
	logic [ACC_W-1:0]        acc_q;
	logic [ACC_BITS_W-1:0]   bits_q;
	logic [BORDER_W-1:0]     prev_q;
	logic [SUM_W-1:0]        rsum_q;
	logic [HPC_W-1:0]        hpc_q;
	logic [CNT_W-1:0]        fc_q;
	logic [CNT_W-1:0]        idx_q;
	logic [LB-1:0]           oc_q;
	logic [ERR_W-1:0]        err_q;
	logic [CNT_W-1:0]        frames_q;
	logic [3:0]              hl_q;
	logic [PAY_W-1:0]        pay_q;
	logic [PART_W-1:0]       quo_q;
	logic [4:0]              rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic                    out_valid_q;

	logic [7:0]              byte_q;
	logic [LB-1:0]           fl_q [MAX_FRAMES];

	logic [1:0]              res_kind_q;
	logic [7:0]              res_ob_q;
	logic [3:0]              res_fi_q;
	logic [13:0]             res_bo_q;
	logic                    res_fd_q;
	logic                    res_sd_q;

	// start-of-superframe setup
	logic [3:0]              n_cfg;
	logic                    n_bad;
	logic [3:0]              hl_cfg;
	logic [PAY_W-1:0]        total;
	logic [PAY_W-1:0]        overhead;

	// header step
	logic [ACC_W-1:0]        acc_sh;
	logic [ACC_BITS_W-1:0]   bits_sum;
	logic [ACC_BITS_W-1:0]   bits_new;
	logic [CNT_W:0]          fc_inc;
	logic                    take;
	logic [3:0]              sh;
	logic [BORDER_W-1:0]     border;
	logic [BORDER_W-1:0]     flen;
	logic [SUM_W-1:0]        rsum_new;
	logic [ACC_W-1:0]        keep_mask;
	logic                    border_ok;
	logic [LB-1:0]           oc_inc;
	logic                    hdr_end;

	// shared frame length read
	logic [CNT_W-1:0]        rd_cnt;
	logic [LB-1:0]           fl_rd;
	logic                    hpp_audio;
	logic                    lpp_end;

	// header finish and divider
	logic [PAY_W-1:0]        last_len;
	logic                    len_bad;
	logic                    a_zero;
	logic                    a_short;
	logic [4:0]              dv_t;
	logic                    dv_ge;

	logic                    idx_end;
	logic                    chk_fail;
	logic                    chk_last;

	assign n_cfg    = frames_for_config(cfg.mode, cfg.rate);
	assign n_bad    = (n_cfg == 4'd0) || (32'(n_cfg) > MAX_FRAMES);
	assign hl_cfg   = header_len(n_cfg);
	assign total    = PAY_W'(cfg.len_a) + PAY_W'(cfg.len_b);
	assign overhead = PAY_W'(hl_cfg) + PAY_W'(n_cfg);

	assign acc_sh    = {acc_q[ACC_W-9:0], byte_q};
	assign bits_sum  = bits_q + ACC_BITS_W'(8);
	assign bits_new  = (bits_sum > ACC_BITS_W'(ACC_W)) ? ACC_BITS_W'(ACC_W) : bits_sum;
	assign fc_inc    = (CNT_W+1)'(fc_q) + (CNT_W+1)'(1);
	assign take      = (bits_new >= ACC_BITS_W'(BORDER_W)) && (fc_inc < (CNT_W+1)'(frames_q));
	assign sh        = 4'(bits_new - ACC_BITS_W'(BORDER_W));
	assign border    = BORDER_W'(acc_sh >> sh);
	assign flen      = border - prev_q;
	assign rsum_new  = rsum_q + SUM_W'(flen);
	assign keep_mask = ACC_W'(((ACC_W+1)'(1) << sh) - (ACC_W+1)'(1));
	assign border_ok = rsum_new < SUM_W'(pay_q);
	assign oc_inc    = oc_q + LB'(1);
	assign hdr_end   = CMP_W'(oc_inc) >= CMP_W'(hl_q);

	assign rd_cnt    = cmd.step ? fc_q : idx_q;
	assign fl_rd     = (32'(rd_cnt) < MAX_FRAMES) ? fl_q[FI_W'(rd_cnt)] : '0;
	assign hpp_audio = CMP_W'(oc_q) < CMP_W'(hpc_q);
	assign lpp_end   = CMP_W'(oc_inc) >= CMP_W'(fl_rd);

	assign last_len  = pay_q - PAY_W'(rsum_q);
	assign len_bad   = (CMP_W+2)'(last_len) > (CMP_W+2)'(LEN_LIMIT);
	assign a_zero    = (cfg.len_a == '0);
	assign a_short   = PAY_W'(cfg.len_a) < (PAY_W'(hl_q) + PAY_W'(frames_q));

	assign dv_t      = {rem_q[3:0], quo_q[PART_W-1]};
	assign dv_ge     = dv_t >= 5'(frames_q);

	assign idx_end   = idx_q >= frames_q;
	assign chk_fail  = CMP_W'(fl_rd) < CMP_W'(hpc_q);
	assign chk_last  = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(frames_q);

	always_comb begin
		sts.step_fin    = (phase_q == PH_HDR) && !(take && !border_ok) && hdr_end;
		sts.step_search = ((phase_q == PH_HPP) && !hpp_audio &&
			(fc_inc >= (CNT_W+1)'(frames_q))) || ((phase_q == PH_LPP) && lpp_end);
		sts.fin_err     = len_bad || (!a_zero && a_short);
		sts.fin_div     = !a_zero;
		sts.div_last    = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
		sts.check_stop  = chk_fail || chk_last;
		sts.search_stop = idx_end || (CMP_W'(fl_rd) > CMP_W'(hpc_q));
		sts.out_free    = !out_valid_q || out_ready;
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			acc_q    <= '0;
			bits_q   <= '0;
			prev_q   <= '0;
			rsum_q   <= '0;
			hpc_q    <= '0;
			fc_q     <= '0;
			idx_q    <= '0;
			oc_q     <= '0;
			err_q    <= ERR_NONE;
			frames_q <= '0;
			hl_q     <= '0;
			pay_q    <= '0;
			quo_q    <= '0;
			rem_q    <= '0;
			dcnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && superframe_start) begin
				acc_q  <= '0;
				bits_q <= '0;
				prev_q <= '0;
				rsum_q <= '0;
				hpc_q  <= '0;
				fc_q   <= '0;
				oc_q   <= '0;
				if (n_bad) begin
					frames_q <= '0;
					err_q    <= ERR_NO_FRAMES;
					phase_q  <= PH_ERR;
				end else begin
					frames_q <= CNT_W'(n_cfg);
					hl_q     <= hl_cfg;
					pay_q    <= (total > overhead) ? total - overhead : '0;
					err_q    <= ERR_NONE;
					phase_q  <= PH_HDR;
				end
			end

			if (cmd.step) begin
				case (phase_q)
					PH_HDR: begin
						oc_q <= oc_inc;
						if (take) begin
							bits_q <= bits_new - ACC_BITS_W'(BORDER_W);
							acc_q  <= acc_sh & keep_mask;
							rsum_q <= rsum_new;
							if (border_ok) begin
								prev_q <= border;
								fc_q   <= fc_q + CNT_W'(1);
							end else begin
								err_q   <= ERR_BORDER;
								phase_q <= PH_ERR;
							end
						end else begin
							bits_q <= bits_new;
							acc_q  <= acc_sh;
						end
					end
					PH_HPP: begin
						if (hpp_audio) begin
							oc_q <= oc_inc;
						end else begin
							oc_q <= '0;
							fc_q <= CNT_W'(fc_inc);
							if (fc_inc >= (CNT_W+1)'(frames_q)) begin
								phase_q <= PH_LPP;
								idx_q   <= '0;
								oc_q    <= LB'(hpc_q);
							end
						end
					end
					PH_LPP: begin
						if (lpp_end) begin
							idx_q <= CNT_W'(fc_inc);
							oc_q  <= LB'(hpc_q);
						end else begin
							oc_q <= oc_inc;
						end
					end
					default: ;
				endcase
			end

			if (cmd.fin) begin
				idx_q  <= '0;
				hpc_q  <= '0;
				quo_q  <= PART_W'(PAY_W'(cfg.len_a) - PAY_W'(hl_q) - PAY_W'(frames_q));
				rem_q  <= '0;
				dcnt_q <= '0;
				if (len_bad) begin
					err_q   <= ERR_BORDER;
					phase_q <= PH_ERR;
				end else if (!a_zero && a_short) begin
					err_q   <= ERR_SHORT;
					phase_q <= PH_ERR;
				end
			end

			// restoring division, one quotient bit a cycle
			if (cmd.div) begin
				rem_q  <= dv_ge ? dv_t - 5'(frames_q) : dv_t;
				quo_q  <= {quo_q[PART_W-2:0], dv_ge};
				dcnt_q <= dcnt_q + DCNT_W'(1);
				if (sts.div_last) hpc_q <= HPC_W'({quo_q[PART_W-2:0], dv_ge});
			end

			if (cmd.check) begin
				if (chk_fail) begin
					err_q   <= ERR_SHORT;
					phase_q <= PH_ERR;
				end else if (chk_last) begin
					phase_q <= PH_HPP;
					fc_q    <= '0;
					oc_q    <= '0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end

			// skip frames whose lower part is empty
			if (cmd.search) begin
				if (sts.search_stop) begin
					fc_q <= idx_q;
					if (idx_end) phase_q <= PH_DONE;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end

			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// byte, frame length store and result words
	always_ff @(posedge clk) begin
		if (cmd.accept) byte_q <= in_byte;

		if (cmd.step && phase_q == PH_HDR && take && border_ok)
			fl_q[FI_W'(fc_q)] <= LB'(flen);
		if (cmd.fin && !len_bad)
			fl_q[FI_W'(frames_q - CNT_W'(1))] <= LB'(last_len);

		if (cmd.step) begin
			res_kind_q <= KIND_DISCARD;
			res_ob_q   <= '0;
			res_fi_q   <= '0;
			res_bo_q   <= '0;
			res_fd_q   <= 1'b0;
			res_sd_q   <= 1'b0;
			case (phase_q)
				PH_HDR: res_kind_q <= KIND_HEADER;
				PH_HPP: begin
					res_ob_q <= byte_q;
					res_fi_q <= 4'(fc_q);
					if (hpp_audio) begin
						res_kind_q <= KIND_AUDIO;
						res_bo_q   <= 14'(oc_q);
						res_fd_q   <= (CMP_W'(oc_inc) == CMP_W'(hpc_q));
					end else begin
						res_kind_q <= KIND_CRC;
					end
				end
				PH_LPP: begin
					res_kind_q <= KIND_AUDIO;
					res_ob_q   <= byte_q;
					res_fi_q   <= 4'(fc_q);
					res_bo_q   <= 14'(oc_q);
					res_fd_q   <= lpp_end;
				end
				default: ;
			endcase
		end

		if (cmd.search && sts.search_stop && idx_end) res_sd_q <= 1'b1;

		if (cmd.emit) begin
			item_kind       <= res_kind_q;
			out_byte        <= res_ob_q;
			frame_index     <= res_fi_q;
			byte_offset     <= res_bo_q;
			frame_done      <= res_fd_q;
			superframe_done <= res_sd_q;
			error_code      <= err_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
